// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the sensor frame deframer.
// Assertions are compiled in unless SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a implies b in the same cycle.
`define SFD_ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("sfd same-cycle assertion failed");
// Check that a implies b in the next cycle.
`define SFD_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("sfd next-cycle assertion failed");
`else
`define SFD_ASSERT_SAME(label, clk, rst_n, a, b)
`define SFD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

// ===== src/sfd_pkg.sv =====
// Shared types and constants of the sensor frame deframer.
// No dependencies.
package sfd_pkg;

  localparam logic [7:0] SYNC_BYTE_RST = 8'd85;
  localparam logic [7:0] END_BYTE_RST  = 8'd102;

  // Configuration register indexes
  localparam logic CFG_SYNC_BYTE = 1'b0;
  localparam logic CFG_END_BYTE  = 1'b1;

  // Event kinds
  localparam logic EV_WORD  = 1'b0;
  localparam logic EV_FRAME = 1'b1;

  typedef struct packed {
    logic               event_kind;
    logic [5:0]         word_index;
    logic signed [15:0] word_value;
    logic [15:0]        frame_id;
    logic [7:0]         open_flags;
    logic               frame_ok;
  } result_t;

endpackage

// ===== src/sfd_out_buf.sv =====
// Two-entry result buffer (output register plus skid register).
// Depends on sfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfd_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfd_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output sfd_pkg::result_t out_data
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  sfd_pkg::result_t out_data_r, out_data_nxt;
  sfd_pkg::result_t skid_data_r, skid_data_nxt;
  logic             pop;

  assign pop       = out_valid_r & out_ready;
  assign can_push  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_data_nxt  = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `SFD_ASSERT_SAME(a_skid_implies_out, clk, rst_n, skid_valid_r, out_valid_r)
  `SFD_ASSERT_SAME(a_no_push_when_full, clk, rst_n, push, !skid_valid_r)
  `SFD_ASSERT_NEXT(a_skid_drains, clk, rst_n, pop && skid_valid_r, out_valid_r && !skid_valid_r)

endmodule

// ===== src/sensor_frame_deframer_top.sv =====
// Top level of the sensor frame deframer: frame parser and result buffer.
// Depends on sfd_pkg, sfd_out_buf and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte) takes one received byte per
//   transfer. The parser hunts for the sync byte, then walks the frame
//   header, emits one result per completed big-endian temperature word and
//   one frame-finished result after the two trailing bytes.
//   Result channel (out_valid/out_ready/out_*) carries at most one result
//   per input byte. event_kind 0 is a word, 1 is a finished frame.
//   Configuration (cfg_we/cfg_index/cfg_wdata): index 0 is the sync byte,
//   index 1 the end byte; write only while the block is idle.
//   Result path: a result is registered at the transfer of the byte that
//   completes it, in the output register or, on a stall, the skid register.
//   One byte per cycle while in_ready is high; parser updates in one pass.
//   Receiver stall: results queue in a two-entry buffer (output register
//   plus skid register); in_ready drops only while both entries are full.
//   Reset (rst_n low, synchronous): parser returns to hunting, buffer
//   empties, sync and end bytes return to 85 and 102.
`include "assert_macros.svh"

module sensor_frame_deframer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_event_kind,
  output logic [5:0]         out_word_index,
  output logic signed [15:0] out_word_value,
  output logic [15:0]        out_frame_id,
  output logic [7:0]         out_open_flags,
  output logic               out_frame_ok,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata
);

  // Parser phases
  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_LEN     = 4'd1;
  localparam logic [3:0] PH_SKIP_A  = 4'd2;
  localparam logic [3:0] PH_ID_HI   = 4'd3;
  localparam logic [3:0] PH_ID_LO   = 4'd4;
  localparam logic [3:0] PH_SKIP_B  = 4'd5;
  localparam logic [3:0] PH_FLAGS   = 4'd6;
  localparam logic [3:0] PH_WORD_HI = 4'd7;
  localparam logic [3:0] PH_WORD_LO = 4'd8;
  localparam logic [3:0] PH_TRAIL1  = 4'd9;
  localparam logic [3:0] PH_TRAIL2  = 4'd10;

  localparam logic [7:0] ID_POS    = 8'd4;
  localparam logic [7:0] FLAGS_POS = 8'd10;

  logic [7:0]  sync_byte_r, end_byte_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  position_r, position_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  held_high_r, held_high_nxt;
  logic [15:0] held_id_r, held_id_nxt;
  logic [7:0]  held_flags_r, held_flags_nxt;
  logic [5:0]  word_count_r, word_count_nxt;

  logic             in_fire;
  logic             res_valid;
  sfd_pkg::result_t res;
  sfd_pkg::result_t out_data;
  logic [7:0]       pos_inc;
  logic signed [9:0] len_s;
  logic             more_words;
  logic             len_match;

  assign in_fire = in_valid & in_ready;
  assign pos_inc = position_r + 8'd1;
  // Length byte is two's complement; widen both sides to compare as integers.
  assign len_s      = $signed({{2{frame_length_r[7]}}, frame_length_r});
  assign more_words = $signed({2'b00, pos_inc}) < (len_s - 10'sd2);
  assign len_match  = $signed({2'b00, pos_inc}) == len_s;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r <= sfd_pkg::SYNC_BYTE_RST;
      end_byte_r  <= sfd_pkg::END_BYTE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sfd_pkg::CFG_SYNC_BYTE: sync_byte_r <= cfg_wdata;
        sfd_pkg::CFG_END_BYTE:  end_byte_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame parser: one pass per accepted byte
  always_comb begin
    phase_nxt        = phase_r;
    position_nxt     = position_r;
    frame_length_nxt = frame_length_r;
    held_high_nxt    = held_high_r;
    held_id_nxt      = held_id_r;
    held_flags_nxt   = held_flags_r;
    word_count_nxt   = word_count_r;
    res_valid        = 1'b0;
    res              = '0;
    if (in_fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_byte == sync_byte_r) begin
            position_nxt   = 8'd1;
            word_count_nxt = '0;
            phase_nxt      = PH_LEN;
          end
        end
        PH_LEN: begin
          frame_length_nxt = in_byte;
          position_nxt     = 8'd2;
          phase_nxt        = PH_SKIP_A;
        end
        PH_SKIP_A: begin
          position_nxt = pos_inc;
          if (pos_inc >= ID_POS) begin
            phase_nxt = PH_ID_HI;
          end
        end
        PH_ID_HI: begin
          held_high_nxt = in_byte;
          position_nxt  = pos_inc;
          phase_nxt     = PH_ID_LO;
        end
        PH_ID_LO: begin
          held_id_nxt  = {held_high_r, in_byte};
          position_nxt = pos_inc;
          phase_nxt    = PH_SKIP_B;
        end
        PH_SKIP_B: begin
          position_nxt = pos_inc;
          if (pos_inc >= FLAGS_POS) begin
            phase_nxt = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          held_flags_nxt = in_byte;
          position_nxt   = pos_inc;
          phase_nxt      = more_words ? PH_WORD_HI : PH_TRAIL1;
        end
        PH_WORD_HI: begin
          held_high_nxt = in_byte;
          position_nxt  = pos_inc;
          phase_nxt     = PH_WORD_LO;
        end
        PH_WORD_LO: begin
          // Emit the completed temperature word
          position_nxt   = pos_inc;
          res_valid      = 1'b1;
          res.event_kind = sfd_pkg::EV_WORD;
          res.word_index = word_count_r;
          res.word_value = $signed({held_high_r, in_byte});
          word_count_nxt = word_count_r + 6'd1;
          phase_nxt      = more_words ? PH_WORD_HI : PH_TRAIL1;
        end
        PH_TRAIL1: begin
          position_nxt = pos_inc;
          phase_nxt    = PH_TRAIL2;
        end
        PH_TRAIL2: begin
          // Report the frame; switch bits are active low (clear = open)
          position_nxt   = pos_inc;
          res_valid      = 1'b1;
          res.event_kind = sfd_pkg::EV_FRAME;
          res.frame_id   = held_id_r;
          res.open_flags = ~held_flags_r;
          res.frame_ok   = len_match & (in_byte == end_byte_r);
          phase_nxt      = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      position_r     <= '0;
      frame_length_r <= '0;
      held_high_r    <= '0;
      held_id_r      <= '0;
      held_flags_r   <= '0;
      word_count_r   <= '0;
    end else begin
      phase_r        <= phase_nxt;
      position_r     <= position_nxt;
      frame_length_r <= frame_length_nxt;
      held_high_r    <= held_high_nxt;
      held_id_r      <= held_id_nxt;
      held_flags_r   <= held_flags_nxt;
      word_count_r   <= word_count_nxt;
    end
  end

  // Result buffer: hold results while the receiver stalls
  sfd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_event_kind = out_data.event_kind;
  assign out_word_index = out_data.word_index;
  assign out_word_value = out_data.word_value;
  assign out_frame_id   = out_data.frame_id;
  assign out_open_flags = out_data.open_flags;
  assign out_frame_ok   = out_data.frame_ok;

  `SFD_ASSERT_SAME(a_result_only_at_word_or_trail, clk, rst_n, res_valid, phase_r == PH_WORD_LO || phase_r == PH_TRAIL2)
  `SFD_ASSERT_NEXT(a_frame_end_hunts, clk, rst_n, in_fire && phase_r == PH_TRAIL2, phase_r == PH_HUNT)
  `SFD_ASSERT_NEXT(a_sync_starts_frame, clk, rst_n, in_fire && phase_r == PH_HUNT && in_byte == sync_byte_r, phase_r == PH_LEN && position_r == 8'd1 && word_count_r == 6'd0)

endmodule
